// ===== design/sprs_pkg.sv =====
package sprs_pkg;

	localparam int MAX_RES = 5;

	// register select, taken from address bit 2
	localparam logic REG_SLOT_MASK = 1'b0;
	localparam logic REG_SEPARATE_MODE = 1'b1;

	localparam logic [1:0] TGT_SHARED = 2'd2;

	typedef enum logic [1:0] {
		ST_ON    = 2'd0,
		ST_STOP  = 2'd1,
		ST_OFF   = 2'd2,
		ST_START = 2'd3
	} run_state_t;

	typedef enum logic [2:0] {
		OP_RUNNING  = 3'd0,
		OP_MASTER   = 3'd1,
		OP_SLOT     = 3'd2,
		OP_SHUTDOWN = 3'd3,
		OP_ARM_TRIP = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		CMD_START       = 3'd0,
		CMD_STOP        = 3'd1,
		CMD_UP          = 3'd2,
		CMD_DOWN        = 3'd3,
		CMD_MASTER_OFF  = 3'd4,
		CMD_SAVE_MASTER = 3'd5,
		CMD_SAVE_SLOT   = 3'd6
	} cmd_t;

	typedef struct packed {
		logic       v;
		cmd_t       cmd;
		logic [1:0] tgt;
		logic       setting;
	} res_t;

	typedef struct packed {
		run_state_t nxt;
		res_t       e0;
		res_t       e1;
	} mach_t;

	function automatic res_t mk_res(logic v, cmd_t cmd, logic [1:0] tgt, logic setting);
		res_t r;
		r.v = v;
		r.cmd = cmd;
		r.tgt = tgt;
		r.setting = setting;
		return r;
	endfunction

	// one step of the on/off machine; power commands only when pwr is set
	function automatic mach_t mach_step(run_state_t st, logic run, logic goal, logic pwr,
			logic s, logic [1:0] tgt);
		mach_t m;
		m.nxt = st;
		m.e0 = mk_res(1'b0, CMD_START, 2'd0, 1'b0);
		m.e1 = mk_res(1'b0, CMD_START, 2'd0, 1'b0);
		case (st)
			ST_ON: begin
				if (!goal) begin
					if (run) begin
						m.e0 = mk_res(1'b1, CMD_STOP, tgt, 1'b0);
						m.nxt = ST_STOP;
					end else begin
						m.e0 = mk_res(pwr, CMD_DOWN, {1'b0, s}, 1'b0);
						m.nxt = ST_OFF;
					end
				end
			end
			ST_STOP: begin
				if (!run) begin
					if (goal) begin
						m.e0 = mk_res(pwr, CMD_UP, {1'b0, s}, 1'b0);
						m.e1 = mk_res(1'b1, CMD_START, tgt, 1'b0);
						m.nxt = ST_START;
					end else begin
						m.e0 = mk_res(pwr, CMD_DOWN, {1'b0, s}, 1'b0);
						m.nxt = ST_OFF;
					end
				end
			end
			ST_OFF: begin
				if (goal) begin
					if (run) begin
						m.nxt = ST_ON;
					end else begin
						m.e0 = mk_res(pwr, CMD_UP, {1'b0, s}, 1'b0);
						m.e1 = mk_res(1'b1, CMD_START, tgt, 1'b0);
						m.nxt = ST_START;
					end
				end
			end
			ST_START: begin
				if (run) begin
					if (goal) begin
						m.nxt = ST_ON;
					end else begin
						m.e0 = mk_res(1'b1, CMD_STOP, tgt, 1'b0);
						m.nxt = ST_STOP;
					end
				end
			end
			default: m.nxt = st;
		endcase
		return m;
	endfunction

endpackage

// ===== design/slot_power_run_sequencer.sv =====
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-------------------------------
// event    | in        | evt_valid / evt_stall | opcode, slot, value
// command  | out       | cmd_valid / cmd_stall | command, target, setting, last
// config   | in        | apb (psel, penable)   | paddr, pwdata / prdata
//
// an event is registered in the input register; from there its commands (zero to five)
// are worked out in one pass and loaded into a five-entry result buffer
// the buffer hands out one command per cycle unless cmd_stall holds it, and
// the buffer's drain sets the sustained rate
// an event with no commands passes the input register without a stall
// reset puts both machines in off and clears the other flags; saved switches read on
// a stalled command holds; the input register keeps taking events while the
// buffer drains, and stalls only when it holds an event with commands to load
module slot_power_run_sequencer
	import sprs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:2]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// event channel
	input  logic        evt_valid,
	output logic        evt_stall,
	input  logic [2:0]  opcode,
	input  logic        slot,
	input  logic        value,
	// command channel
	output logic        cmd_valid,
	input  logic        cmd_stall,
	output logic [2:0]  command,
	output logic [1:0]  target,
	output logic        setting,
	output logic        last
);

	// configuration registers
	logic [1:0] slot_mask_q;
	logic       sep_q;

	// sequencer state
	run_state_t rs_q [2];
	logic [1:0] run_q;
	logic [1:0] pw_q;
	logic       mgoal_q;
	logic [1:0] sgoal_q;
	logic       msaved_q;
	logic [1:0] ssaved_q;
	logic       shut_q;
	logic       trip_q;

	// input register
	logic       v_s1;
	logic [2:0] op_s1;
	logic       slot_s1;
	logic       value_s1;

	// result buffer
	res_t       rbuf_q [MAX_RES];
	logic [2:0] n_q;
	logic [2:0] rd_q;

	// next-state and generated command list
	run_state_t rs_n [2];
	logic [1:0] run_n;
	logic [1:0] pw_n;
	logic       mgoal_n;
	logic [1:0] sgoal_n;
	logic       msaved_n;
	logic [1:0] ssaved_n;
	logic       shut_n;
	logic       trip_n;
	res_t       cand [MAX_RES];
	res_t       gen [MAX_RES];
	logic [2:0] gen_n;

	logic       cmd_fire;
	logic       drain_done;
	logic       advance;

	//---------------------------------------------------------------
	// configuration port
	//---------------------------------------------------------------
	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			REG_SLOT_MASK:     prdata = {30'd0, slot_mask_q};
			REG_SEPARATE_MODE: prdata = {31'd0, sep_q};
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_mask_q <= 2'b11;
			sep_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_SLOT_MASK:     slot_mask_q <= pwdata[1:0];
				REG_SEPARATE_MODE: sep_q <= pwdata[0];
				default:           ;
			endcase
		end
	end

	//---------------------------------------------------------------
	// handshakes
	//---------------------------------------------------------------
	assign cmd_valid = (rd_q != n_q);
	assign cmd_fire = cmd_valid && !cmd_stall;
	// buffer is empty, or its final command leaves this cycle
	assign drain_done = !cmd_valid || (cmd_fire && (rd_q + 3'd1 == n_q));
	assign advance = v_s1 && (drain_done || gen_n == 3'd0);
	assign evt_stall = v_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!evt_stall) begin
			v_s1 <= evt_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) begin
			op_s1 <= opcode;
			slot_s1 <= slot;
			value_s1 <= value;
		end
	end

	//---------------------------------------------------------------
	// one pass: flag update, goals, machines, command list
	//---------------------------------------------------------------
	always_comb begin
		logic       do_act;
		logic       goal0;
		logic       goal1;
		logic       mism;
		logic       proceed;
		run_state_t rs0_mid;
		mach_t      m0;
		mach_t      m1;
		mach_t      ms;
		res_t       pre;
		res_t       a0;
		res_t       a1;
		res_t       b0;
		res_t       b1;
		logic [2:0] pos;

		rs_n[0] = rs_q[0];
		rs_n[1] = rs_q[1];
		run_n = run_q;
		pw_n = pw_q;
		mgoal_n = mgoal_q;
		sgoal_n = sgoal_q;
		msaved_n = msaved_q;
		ssaved_n = ssaved_q;
		shut_n = shut_q;
		trip_n = trip_q;
		do_act = 1'b0;
		pre = mk_res(1'b0, CMD_START, 2'd0, 1'b0);
		a0 = pre;
		a1 = pre;
		b0 = pre;
		b1 = pre;
		proceed = 1'b0;
		rs0_mid = rs_q[0];

		// event itself: flag writes and the leading command
		case (op_s1)
			OP_RUNNING: begin
				run_n[slot_s1] = value_s1;
				do_act = 1'b1;
			end
			OP_MASTER: begin
				pre = mk_res(msaved_q != value_s1, CMD_SAVE_MASTER, 2'd0, value_s1);
				mgoal_n = value_s1;
				msaved_n = value_s1;
				do_act = 1'b1;
			end
			OP_SLOT: begin
				pre = mk_res(ssaved_q[slot_s1] != value_s1, CMD_SAVE_SLOT,
					{1'b0, slot_s1}, value_s1);
				sgoal_n[slot_s1] = value_s1;
				ssaved_n[slot_s1] = value_s1;
				do_act = 1'b1;
			end
			OP_SHUTDOWN: begin
				shut_n = value_s1;
				// trip only matters while the master goal is on
				pre = mk_res(value_s1 && mgoal_q && trip_q, CMD_MASTER_OFF, 2'd0, 1'b0);
				do_act = 1'b1;
			end
			OP_ARM_TRIP: trip_n = value_s1;
			default: ;
		endcase

		goal0 = slot_mask_q[0] && mgoal_n && sgoal_n[0] && !shut_n;
		goal1 = slot_mask_q[1] && mgoal_n && sgoal_n[1] && !shut_n;

		m0 = mach_step(rs_q[0], run_n[0], goal0, 1'b1, 1'b0, 2'd0);
		m1 = mach_step(rs_q[1], run_n[1], goal1, 1'b1, 1'b1, 2'd1);

		// shared worker must be stopped before slot power moves
		mism = (goal0 != pw_q[0]) || (goal1 != pw_q[1]);
		if (mism) begin
			case (rs_q[0])
				ST_ON: begin
					if (run_n[0]) begin
						a0 = mk_res(1'b1, CMD_STOP, TGT_SHARED, 1'b0);
						rs0_mid = ST_STOP;
					end
				end
				ST_STOP: begin
					if (!run_n[0]) begin
						rs0_mid = ST_OFF;
						proceed = 1'b1;
					end
				end
				ST_OFF: proceed = !run_n[0];
				ST_START: begin
					if (run_n[0]) begin
						a0 = mk_res(1'b1, CMD_STOP, TGT_SHARED, 1'b0);
						rs0_mid = ST_STOP;
					end
				end
				default: ;
			endcase
		end else begin
			proceed = 1'b1;
		end
		ms = mach_step(rs0_mid, run_n[0], goal0 || goal1, 1'b0, 1'b0, TGT_SHARED);

		if (do_act) begin
			if (sep_q) begin
				if (slot_mask_q[0]) begin
					a0 = m0.e0;
					a1 = m0.e1;
					rs_n[0] = m0.nxt;
				end else begin
					a0 = mk_res(1'b0, CMD_START, 2'd0, 1'b0);
				end
				if (slot_mask_q[1]) begin
					b0 = m1.e0;
					b1 = m1.e1;
					rs_n[1] = m1.nxt;
				end
			end else begin
				rs_n[0] = rs0_mid;
				if (proceed) begin
					a0 = mk_res(goal0 != pw_q[0], goal0 ? CMD_UP : CMD_DOWN, 2'd0, 1'b0);
					a1 = mk_res(goal1 != pw_q[1], goal1 ? CMD_UP : CMD_DOWN, 2'd1, 1'b0);
					pw_n[0] = goal0;
					pw_n[1] = goal1;
					b0 = ms.e0;
					b1 = ms.e1;
					rs_n[0] = ms.nxt;
				end
			end
		end else begin
			a0 = mk_res(1'b0, CMD_START, 2'd0, 1'b0);
		end

		cand[0] = pre;
		cand[1] = a0;
		cand[2] = a1;
		cand[3] = b0;
		cand[4] = b1;

		// pack the valid candidates to the front, order kept
		for (int j = 0; j < MAX_RES; j++) begin
			gen[j] = mk_res(1'b0, CMD_START, 2'd0, 1'b0);
		end
		pos = 3'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			if (cand[i].v) begin
				gen[pos] = cand[i];
				pos = pos + 3'd1;
			end
		end
		gen_n = pos;
	end

	//---------------------------------------------------------------
	// state update, taken when the event leaves the input register
	//---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q[0] <= ST_OFF;
			rs_q[1] <= ST_OFF;
			run_q <= 2'b00;
			pw_q <= 2'b00;
			mgoal_q <= 1'b0;
			sgoal_q <= 2'b00;
			msaved_q <= 1'b1;
			ssaved_q <= 2'b11;
			shut_q <= 1'b0;
			trip_q <= 1'b0;
		end else if (advance) begin
			rs_q[0] <= rs_n[0];
			rs_q[1] <= rs_n[1];
			run_q <= run_n;
			pw_q <= pw_n;
			mgoal_q <= mgoal_n;
			sgoal_q <= sgoal_n;
			msaved_q <= msaved_n;
			ssaved_q <= ssaved_n;
			shut_q <= shut_n;
			trip_q <= trip_n;
		end
	end

	//---------------------------------------------------------------
	// result buffer: loaded whole, drained unless stalled at one transfer per cycle
	//---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 3'd0;
			rd_q <= 3'd0;
		end else if (advance && gen_n != 3'd0) begin
			n_q <= gen_n;
			rd_q <= 3'd0;
		end else if (cmd_fire) begin
			rd_q <= rd_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && gen_n != 3'd0) begin
			for (int k = 0; k < MAX_RES; k++) begin
				rbuf_q[k] <= gen[k];
			end
		end
	end

	always_comb begin
		res_t cur;
		cur = rbuf_q[0];
		for (int k = 0; k < MAX_RES; k++) begin
			if (rd_q == 3'(k)) begin
				cur = rbuf_q[k];
			end
		end
		command = cur.cmd;
		target = cur.tgt;
		setting = cur.setting;
		last = (rd_q + 3'd1 == n_q);
	end

	//---------------------------------------------------------------
	// assertions
	//---------------------------------------------------------------
	a_buf_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q <= 3'(MAX_RES)) && (rd_q <= n_q))
		else $error("result buffer pointer out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && gen_n != 3'd0) |-> drain_done)
		else $error("result buffer loaded while commands still pending");

	a_run_on: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && !last) |=> cmd_valid)
		else $error("command run ended without a last flag");

	a_single_worker: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !sep_q && (command == CMD_START || command == CMD_STOP))
			|-> target == TGT_SHARED)
		else $error("worker command in single mode not aimed at shared worker");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import sprs_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 8;
	// an event passes the input register before its commands are loaded
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 12;
	localparam int HOLD_CYCLES = 64;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int N_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 16;

	// opcodes past arm trip are undefined and must be dropped
	localparam logic [2:0] OP_RESERVED_LO = 3'd5;
	localparam logic [2:0] OP_RESERVED_HI = 3'd7;
	// master commands carry no slot
	localparam logic [1:0] TGT_NONE = 2'd0;

	// per phase: fitted slots, worker mode, sender idle and receiver stall percentages
	localparam int PH_MASK[N_PHASES]  = '{3, 1, 2, 0, 3, 1};
	localparam int PH_SPLIT[N_PHASES] = '{1, 1, 0, 1, 0, 0};
	localparam int PH_IDLE[N_PHASES]  = '{0, 61, 0, 19, 0, 19};
	localparam int PH_STALL[N_PHASES] = '{0, 0, 61, 19, 0, 19};

	typedef struct packed {
		cmd_t       cmd;
		logic [1:0] tgt;
		logic       setting;
		logic       last;
	} cmd_rec_t;

	// tracks the sequencer state and the commands still owed by accepted events
	class power_seq_scoreboard;
		logic [1:0] fitted;
		logic       split;
		run_state_t phase[2];
		bit         worker_on[2];
		bit         powered[2];
		bit         master_want;
		bit         slot_want[2];
		bit         master_mem;
		bit         slot_mem[2];
		bit         shutdown;
		bit         trip;
		cmd_rec_t   batch[$];
		cmd_rec_t   pending_cmds[$];
		int         errors;
		int         events_seen;
		int         cmds_seen;

		function new();
			fitted = 2'b11;
			split = 1'b0;
			for (int i = 0; i < 2; i++) begin
				phase[i] = ST_OFF;
				worker_on[i] = 1'b0;
				powered[i] = 1'b0;
				slot_want[i] = 1'b0;
				slot_mem[i] = 1'b1;
			end
			master_want = 1'b0;
			master_mem = 1'b1;
			shutdown = 1'b0;
			trip = 1'b0;
			errors = 0;
			events_seen = 0;
			cmds_seen = 0;
		endfunction

		function void push_cmd(cmd_t c, logic [1:0] t, logic st);
			cmd_rec_t r;
			if (batch.size() >= MAX_RES)
				return;
			r.cmd = c;
			r.tgt = t;
			r.setting = st;
			r.last = 1'b0;
			batch.push_back(r);
		endfunction

		function bit goal_on(bit s);
			return fitted[s] && master_want && slot_want[s] && !shutdown;
		endfunction

		function bit likely_running(bit s);
			return phase[s] == ST_START || phase[s] == ST_ON;
		endfunction

		function void step_worker(bit s, logic [1:0] t, bit pwr, bit g);
			bit run;
			run = worker_on[s];
			case (phase[s])
				ST_ON: if (!g) begin
					if (run) begin
						push_cmd(CMD_STOP, t, 1'b0);
						phase[s] = ST_STOP;
					end else begin
						if (pwr)
							push_cmd(CMD_DOWN, {1'b0, s}, 1'b0);
						phase[s] = ST_OFF;
					end
				end
				ST_STOP: if (!run) begin
					if (g) begin
						if (pwr)
							push_cmd(CMD_UP, {1'b0, s}, 1'b0);
						push_cmd(CMD_START, t, 1'b0);
						phase[s] = ST_START;
					end else begin
						if (pwr)
							push_cmd(CMD_DOWN, {1'b0, s}, 1'b0);
						phase[s] = ST_OFF;
					end
				end
				ST_OFF: if (g) begin
					if (run) begin
						phase[s] = ST_ON;
					end else begin
						if (pwr)
							push_cmd(CMD_UP, {1'b0, s}, 1'b0);
						push_cmd(CMD_START, t, 1'b0);
						phase[s] = ST_START;
					end
				end
				ST_START: if (run) begin
					if (g) begin
						phase[s] = ST_ON;
					end else begin
						push_cmd(CMD_STOP, t, 1'b0);
						phase[s] = ST_STOP;
					end
				end
				default: ;
			endcase
		endfunction

		function void set_power(bit s, bit want);
			if (want == powered[s])
				return;
			push_cmd(want ? CMD_UP : CMD_DOWN, {1'b0, s}, 1'b0);
			powered[s] = want;
		endfunction

		// shared worker must be down before any slot power change
		function void shared_step();
			bit w0, w1, run;
			w0 = goal_on(1'b0);
			w1 = goal_on(1'b1);
			run = worker_on[0];
			if (w0 != powered[0] || w1 != powered[1]) begin
				case (phase[0])
					ST_ON: begin
						if (run) begin
							push_cmd(CMD_STOP, TGT_SHARED, 1'b0);
							phase[0] = ST_STOP;
						end
						return;
					end
					ST_STOP: begin
						if (run)
							return;
						phase[0] = ST_OFF;
					end
					ST_OFF: begin
						if (run)
							return;
					end
					ST_START: begin
						if (run) begin
							push_cmd(CMD_STOP, TGT_SHARED, 1'b0);
							phase[0] = ST_STOP;
						end
						return;
					end
					default: ;
				endcase
				set_power(1'b0, w0);
				set_power(1'b1, w1);
			end
			step_worker(1'b0, TGT_SHARED, 1'b0, w0 || w1);
		endfunction

		function void act();
			if (split) begin
				for (int i = 0; i < 2; i++)
					if (fitted[i])
						step_worker(i[0], {1'b0, i[0]}, 1'b1, goal_on(i[0]));
			end else begin
				shared_step();
			end
		endfunction

		function void note_event(logic [2:0] op, logic s, logic v);
			batch.delete();
			events_seen++;
			case (op)
				OP_RUNNING: begin
					worker_on[s] = v;
					act();
				end
				OP_MASTER: begin
					if (master_mem != v)
						push_cmd(CMD_SAVE_MASTER, TGT_NONE, v);
					master_want = v;
					master_mem = v;
					act();
				end
				OP_SLOT: begin
					if (slot_mem[s] != v)
						push_cmd(CMD_SAVE_SLOT, {1'b0, s}, v);
					slot_want[s] = v;
					slot_mem[s] = v;
					act();
				end
				OP_SHUTDOWN: begin
					shutdown = v;
					if (shutdown && master_want && trip)
						push_cmd(CMD_MASTER_OFF, TGT_NONE, 1'b0);
					act();
				end
				OP_ARM_TRIP: trip = v;
				default: ;
			endcase
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i])
				pending_cmds.push_back(batch[i]);
		endfunction

		function void check_cmd(logic [2:0] c, logic [1:0] t, logic st, logic l);
			cmd_rec_t e;
			cmds_seen++;
			if (pending_cmds.size() == 0) begin
				$error("command %0d target %0d arrived with nothing pending", c, t);
				errors++;
				return;
			end
			e = pending_cmds.pop_front();
			if (c !== e.cmd) begin
				$error("command: expected %0d, got %0d", e.cmd, c);
				errors++;
			end
			if (t !== e.tgt) begin
				$error("target: expected %0d, got %0d", e.tgt, t);
				errors++;
			end
			if (st !== e.setting) begin
				$error("setting: expected %0d, got %0d", e.setting, st);
				errors++;
			end
			if (l !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, l);
				errors++;
			end
		endfunction
	endclass

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// configuration port, idle until a register write
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:2]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// event channel
	logic       evt_valid = 1'b0;
	logic       evt_stall;
	logic [2:0] opcode = '0;
	logic       slot = 1'b0;
	logic       value = 1'b0;

	// command channel
	logic       cmd_valid;
	logic       cmd_stall = 1'b0;
	logic [2:0] command;
	logic [1:0] target;
	logic       setting;
	logic       last;

	// traffic shaping, set per phase by the stimulus
	int idle_pct = 0;
	int stall_pct = 0;
	// long receiver hold-offs: requested by the stimulus, served by the receiver
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int settings_used = 0;

	power_seq_scoreboard sb;

	always #HALF_PERIOD clk = ~clk;

	slot_power_run_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.opcode    (opcode),
		.slot      (slot),
		.value     (value),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.command   (command),
		.target    (target),
		.setting   (setting),
		.last      (last)
	);

	// receiver: random stall, or a long hold-off counted here so the block backs up
	always @(negedge clk) begin
		if (hold_left == 0 && hold_taken != hold_asked) begin
			hold_taken++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			cmd_stall <= 1'b1;
		end else begin
			cmd_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// every command transfer is checked against the oldest pending one
	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall)
			sb.check_cmd(command, target, setting, last);
	end

	// watchdog: too long without a transfer on either channel ends the run
	always @(posedge clk) begin
		if ((evt_valid && !evt_stall) || (cmd_valid && !cmd_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles, %0d commands pending",
				quiet_cycles, sb.pending_cmds.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// offer one event, with random idle cycles first; returns at a falling edge
	task automatic send_event(logic [2:0] op, logic s, logic v);
		while ($urandom_range(99) < idle_pct) begin
			evt_valid <= 1'b0;
			@(negedge clk);
		end
		evt_valid <= 1'b1;
		opcode <= op;
		slot <= s;
		value <= v;
		@(posedge clk);
		while (evt_stall)
			@(posedge clk);
		sb.note_event(op, s, v);
		@(negedge clk);
	endtask

	// stop offering and wait until every owed command has come out
	task automatic wait_drained();
		evt_valid <= 1'b0;
		while (sb.pending_cmds.size() != 0)
			@(posedge clk);
		// an event with no commands may still sit in the input register
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// apb write, then read back; starts and ends at a falling edge
	task automatic write_reg(logic sel, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= sel;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (sel == REG_SLOT_MASK)
			sb.fitted = data[1:0];
		else
			sb.split = data[0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (sel == REG_SLOT_MASK && prdata[1:0] !== data[1:0]) begin
			$error("slot_mask readback: expected %0d, got %0d", data[1:0], prdata[1:0]);
			sb.errors++;
		end
		if (sel == REG_SEPARATE_MODE && prdata[0] !== data[0]) begin
			$error("separate_mode readback: expected %0d, got %0d", data[0], prdata[0]);
			sb.errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [2:0] op;
		logic       s;
		logic       v;
		int         pick;

		sb = new();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		settings_used = 1;

		// directed: shared worker with both slots fitted, as after reset
		send_event(OP_RESERVED_LO, 1'b1, 1'b1);     // undefined opcodes are dropped
		send_event(OP_RESERVED_HI, 1'b0, 1'b0);
		send_event(OP_ARM_TRIP, 1'b0, 1'b1);        // arm only, no commands
		send_event(OP_MASTER, 1'b0, 1'b1);          // matches saved switch, no save
		send_event(OP_SLOT, 1'b0, 1'b1);            // power slot 0 up, start worker
		send_event(OP_RUNNING, 1'b0, 1'b1);         // worker confirms, machine on
		send_event(OP_RUNNING, 1'b1, 1'b1);         // slot 1 report ignored by shared worker
		send_event(OP_SLOT, 1'b1, 1'b1);            // power change needs the worker stopped
		send_event(OP_RUNNING, 1'b0, 1'b0);         // stopped: power slot 1, restart
		send_event(OP_RUNNING, 1'b0, 1'b1);
		send_event(OP_SHUTDOWN, 1'b0, 1'b1);        // trip armed: master off goes first
		send_event(OP_RUNNING, 1'b0, 1'b0);         // both slots powered down
		send_event(OP_SHUTDOWN, 1'b0, 1'b0);        // both up again plus start
		send_event(OP_RUNNING, 1'b0, 1'b1);
		send_event(OP_RUNNING, 1'b0, 1'b1);         // already running while on: nothing
		send_event(OP_MASTER, 1'b0, 1'b0);          // save master off, stop
		send_event(OP_RUNNING, 1'b1, 1'b0);
		send_event(OP_MASTER, 1'b0, 1'b1);          // save master on
		send_event(OP_SLOT, 1'b1, 1'b0);            // save slot 1 off
		send_event(OP_ARM_TRIP, 1'b1, 1'b0);
		send_event(OP_SHUTDOWN, 1'b1, 1'b1);        // trip disarmed: no master off
		send_event(OP_RUNNING, 1'b0, 1'b0);
		send_event(OP_SHUTDOWN, 1'b0, 1'b0);
		send_event(OP_SLOT, 1'b1, 1'b1);            // save slot 1 on

		// random phases, each under its own register setting and traffic pattern
		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			write_reg(REG_SLOT_MASK, PH_MASK[ph]);
			write_reg(REG_SEPARATE_MODE, PH_SPLIT[ph]);
			settings_used++;
			idle_pct = PH_IDLE[ph];
			stall_pct = PH_STALL[ph];
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// long hold-off while events keep coming in: the block must back up
				if (ph == 0 && n == 4)
					hold_asked++;
				// sender pause until all owed commands are out
				if (ph == 2 && n == 10)
					wait_drained();
				pick = $urandom_range(99);
				s = 1'($urandom_range(1));
				v = 1'($urandom_range(1));
				if (pick < 35) begin
					// running reports mostly answer what the worker was told to do
					op = OP_RUNNING;
					if (!sb.split && $urandom_range(3) != 0)
						s = 1'b0;
					if ($urandom_range(9) < 7)
						v = sb.likely_running(s);
				end else if (pick < 50) begin
					op = OP_MASTER;
					v = ($urandom_range(3) != 0);
				end else if (pick < 72) begin
					op = OP_SLOT;
					v = ($urandom_range(3) != 0);
				end else if (pick < 85) begin
					op = OP_SHUTDOWN;
					v = ($urandom_range(9) < 3);
				end else if (pick < 95) begin
					op = OP_ARM_TRIP;
				end else begin
					op = 3'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO));
				end
				send_event(op, s, v);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending_cmds.size() != 0) begin
			$error("%0d commands never arrived", sb.pending_cmds.size());
			sb.errors++;
		end

		$display("run covered %0d events and %0d commands under %0d register settings,",
			sb.events_seen, sb.cmds_seen, settings_used);
		$display("with shared and per-slot workers, idle and stall mixes and a long hold-off");
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
